// ===== rtl/next_password_candidate_assert.svh =====
// Assertion macros used by the checker file.
`ifndef NEXT_PASSWORD_CANDIDATE_ASSERT_SVH
`define NEXT_PASSWORD_CANDIDATE_ASSERT_SVH

// Property checked only while reset is released.
`define NPC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("npc assertion failed");

// Property checked at every edge, reset included.
`define NPC_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("npc assertion failed during or after reset");

`endif

// ===== rtl/npc_pkg.sv =====
package npc_pkg;

    localparam int MAX_LEN     = 8;
    localparam int ALPHA_MAX   = 32;
    localparam int CHAR_W      = 8;
    localparam int LEN_W       = 4;
    localparam int ALPHA_IDX_W = 5;
    localparam int ALPHA_LEN_W = 6;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_W       = 64;
    localparam int WORD_SYMS   = CFG_W / CHAR_W;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_WORD0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_WORD1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_WORD2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_WORD3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_LEN   = 3'd4;

    typedef logic [CHAR_W-1:0]                 t_char;
    typedef logic [ALPHA_MAX-1:0][CHAR_W-1:0]  t_alphabet;
    typedef logic [MAX_LEN-1:0][CHAR_W-1:0]    t_chars;

    typedef struct packed {
        t_chars           cand_chars;
        logic [LEN_W-1:0] cand_len;
    } t_cand_in;

    typedef struct packed {
        t_chars           next_chars;
        logic [LEN_W-1:0] next_len;
        logic             overflow;
    } t_cand_out;

    // Per-character successor lookup result
    typedef struct packed {
        logic  wrap;
        t_char succ;
    } t_char_step;

    // Index of the last symbol in use: 0 counts as 1, above ALPHA_MAX saturates
    function automatic logic [ALPHA_IDX_W-1:0] alpha_last_idx(
        input logic [ALPHA_LEN_W-1:0] len
    );
        logic [ALPHA_IDX_W-1:0] idx;
        if (len == '0) begin
            idx = '0;
        end else if (len > ALPHA_LEN_W'(ALPHA_MAX)) begin
            idx = ALPHA_IDX_W'(ALPHA_MAX - 1);
        end else begin
            idx = ALPHA_IDX_W'(len - 1'b1);
        end
        return idx;
    endfunction

endpackage

// ===== rtl/npc_char_step.sv =====
module npc_char_step
    import npc_pkg::*;
(
    input  t_alphabet              i_alpha,
    input  logic [ALPHA_IDX_W-1:0] i_last_idx,
    input  t_char                  i_char,
    output t_char_step             o_step
);

    logic [ALPHA_MAX-1:0]   match;
    logic [ALPHA_IDX_W-1:0] found;
    logic                   hit;

    // Compare against every symbol in use
    always_comb begin
        for (int k = 0; k < ALPHA_MAX; k++) begin
            match[k] = (i_alpha[k] == i_char) && (ALPHA_IDX_W'(k) <= i_last_idx);
        end
    end

    // First matching position wins (duplicates)
    always_comb begin
        found = '0;
        for (int k = ALPHA_MAX - 1; k >= 0; k--) begin
            if (match[k]) begin
                found = ALPHA_IDX_W'(k);
            end
        end
    end

    assign hit = |match;

    // Missing symbol or last symbol wraps to symbol 0 and carries
    always_comb begin
        o_step.wrap = !hit || (found == i_last_idx);
        if (o_step.wrap) begin
            o_step.succ = i_alpha[0];
        end else begin
            o_step.succ = i_alpha[ALPHA_IDX_W'(found + 1'b1)];
        end
    end

endmodule

// ===== rtl/next_password_candidate.sv =====
// Next brute-force password candidate in odometer order over a configured
// byte alphabet of up to 32 symbols.
// Input channel: i_in_valid / o_in_stall carry a candidate (chars, length).
// Output channel: o_out_valid / i_out_stall carry the successor, its length
// and an overflow flag; on overflow the candidate comes back unchanged with
// bytes past its length cleared.
// Configuration: i_cfg_we with i_cfg_idx / i_cfg_data writes alphabet words
// 0..3 and the alphabet length (index 4); write only while idle.
// Datapath: input register, one combinational lookup and carry pass,
// result register.
// Throughput: one transaction per cycle unless the receiver stalls; the alphabet lookup
// and an 8-position carry chain sit between the two registers.
// When the receiver stalls, the result holds; o_in_stall rises in the same
// cycle once the input register also holds a transaction.
// Reset clears both valid flags, the alphabet to all zero bytes and the
// alphabet length to 1.
module next_password_candidate
    import npc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_cand_in             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_cand_out            o_out_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    t_alphabet              r_alpha;
    logic [ALPHA_IDX_W-1:0] r_last_idx;
    logic                   r_in_vld;
    logic                   r_out_vld;
    t_cand_in               r_in;
    t_cand_out              r_out;
    t_cand_out              n_out;

    logic                   move_out;
    logic                   in_take;
    t_char_step             step [MAX_LEN];
    t_chars                 kept;
    t_chars                 bumped;
    t_chars                 grown;
    logic                   carry;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha    <= '0;
            r_last_idx <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ALPHA_WORD0: r_alpha[WORD_SYMS-1:0]               <= i_cfg_data;
                CFG_ALPHA_WORD1: r_alpha[2*WORD_SYMS-1:WORD_SYMS]     <= i_cfg_data;
                CFG_ALPHA_WORD2: r_alpha[3*WORD_SYMS-1:2*WORD_SYMS]   <= i_cfg_data;
                CFG_ALPHA_WORD3: r_alpha[4*WORD_SYMS-1:3*WORD_SYMS]   <= i_cfg_data;
                CFG_ALPHA_LEN:   r_last_idx <= alpha_last_idx(i_cfg_data[ALPHA_LEN_W-1:0]);
                default: ;
            endcase
        end
    end

    // Two-slot pipeline handshake
    assign move_out    = r_in_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall  = r_in_vld && !move_out;
    assign in_take     = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (!o_in_stall) begin
                r_in_vld <= i_in_valid;
            end
            if (move_out) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in_data;
        end
        if (move_out) begin
            r_out <= n_out;
        end
    end

    // Successor lookup per character position
    for (genvar p = 0; p < MAX_LEN; p++) begin : g_pos
        npc_char_step u_step (
            .i_alpha    (r_alpha),
            .i_last_idx (r_last_idx),
            .i_char     (r_in.cand_chars[p]),
            .o_step     (step[p])
        );
    end

    // Carry chain from the last character leftward
    always_comb begin
        carry = 1'b1;
        for (int p = MAX_LEN - 1; p >= 0; p--) begin
            if (LEN_W'(p) < r_in.cand_len) begin
                kept[p]   = r_in.cand_chars[p];
                bumped[p] = carry ? step[p].succ : r_in.cand_chars[p];
                carry     = carry & step[p].wrap;
            end else begin
                kept[p]   = '0;
                bumped[p] = '0;
            end
            grown[p] = (LEN_W'(p) <= r_in.cand_len) ? r_alpha[0] : '0;
        end
    end

    // Result selection: increment, growth or overflow
    always_comb begin
        n_out.next_chars = kept;
        n_out.next_len   = r_in.cand_len;
        n_out.overflow   = 1'b1;
        if (r_in.cand_len > LEN_W'(MAX_LEN)) begin
            n_out.overflow = 1'b1;
        end else if (!carry) begin
            n_out.next_chars = bumped;
            n_out.overflow   = 1'b0;
        end else if (r_in.cand_len == LEN_W'(MAX_LEN)) begin
            n_out.overflow = 1'b1;
        end else begin
            n_out.next_chars = grown;
            n_out.next_len   = r_in.cand_len + LEN_W'(1);
            n_out.overflow   = 1'b0;
        end
    end

endmodule

// ===== rtl/npc_checker.sv =====
`include "next_password_candidate_assert.svh"

module npc_checker
    import npc_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_in_stall,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input t_cand_out            o_out_data
);

    logic out_held;
    logic out_normal;
    logic len_ok;

    assign out_held   = o_out_valid && i_out_stall;
    assign out_normal = o_out_valid && !o_out_data.overflow;
    assign len_ok     = (o_out_data.next_len != '0) && (o_out_data.next_len <= LEN_W'(MAX_LEN));

    // Reset empties the output register
    `NPC_ASSERT_ALWAYS(a_rst_clears_out, i_clk, !i_rst_n |=> !o_out_valid)

    // Input side only stalls when both slots are full and the output is held
    `NPC_ASSERT(a_stall_only_when_full, i_clk, i_rst_n, o_in_stall |-> out_held)

    // A held result does not change
    `NPC_ASSERT(a_out_hold, i_clk, i_rst_n, out_held |=> (o_out_valid && $stable(o_out_data)))

    // A normal successor is never empty and never longer than the maximum
    `NPC_ASSERT(a_len_range, i_clk, i_rst_n, out_normal |-> len_ok)

endmodule

bind next_password_candidate npc_checker u_npc_checker (.*);
